// File: rtl/core/lebg_pkg.sv
package lebg_pkg;

    localparam int TIME_W   = 32;
    localparam int BR_W     = 8;
    localparam int PER_W    = 16;
    localparam int QUO_W    = 8;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W    = $clog2(DIV_STEPS);

    localparam logic [2:0] MODE_CONST   = 3'd0;
    localparam logic [2:0] MODE_BLINK   = 3'd1;
    localparam logic [2:0] MODE_FADEON  = 3'd2;
    localparam logic [2:0] MODE_FADEOFF = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;
    localparam logic [2:0] MODE_ADVBR   = 3'd5;
    localparam logic [2:0] MODE_CANDLE  = 3'd6;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_LEVEL    = 3'd1;
    localparam logic [2:0] REG_SPAN     = 3'd2;
    localparam logic [2:0] REG_ON       = 3'd3;
    localparam logic [2:0] REG_OFF      = 3'd4;
    localparam logic [2:0] REG_SPEED    = 3'd5;
    localparam logic [2:0] REG_JITTER   = 3'd6;
    localparam logic [2:0] REG_SEED     = 3'd7;

    localparam logic [31:0] RAND_FEEDBACK = 32'h7FFF_F159;
    localparam logic [7:0]  CANDLE_BASE   = 8'd50;
    localparam logic [7:0]  FULL_LEVEL    = 8'hFF;
    localparam logic [7:0]  CANDLE_RESET  = 8'd5;

    localparam logic [7:0] CURVE_PTS [9] = '{
        8'd0, 8'd3, 8'd13, 8'd33, 8'd68, 8'd118, 8'd179, 8'd232, 8'd255
    };

    localparam logic [7:0] FLICKER_TAB [16] = '{
        8'd5, 8'd10, 8'd20, 8'd30, 8'd50, 8'd20, 8'd30, 8'd40,
        8'd50, 8'd60, 8'd70, 8'd80, 8'd90, 8'd100, 8'd110, 8'd255
    };

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  level;
        logic [15:0] time_span;
        logic [15:0] time_on;
        logic [15:0] time_off;
        logic [4:0]  flicker_speed;
        logic [7:0]  flicker_jitter;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic select;
        logic load;
        logic divide;
        logic interp;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic fade_req;
        logic out_free;
    } dp_sts_t;

endpackage

// File: rtl/core/lebg_ctrl.sv
module lebg_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  lebg_pkg::dp_sts_t sts,
    output lebg_pkg::dp_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SELECT = 6'b000010,
        ST_LOAD   = 6'b000100,
        ST_DIVIDE = 6'b001000,
        ST_INTERP = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [lebg_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_SELECT;
                end
            end
            ST_SELECT: begin
                cmd.select = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (sts.fade_req) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIVIDE;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DIVIDE: begin
                cmd.divide = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == lebg_pkg::CNT_W'(lebg_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP: begin
                cmd.interp = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: rtl/core/lebg_dp.sv
module lebg_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  lebg_pkg::cfg_t    cfg,
    input  logic              seed_wr,
    input  logic [31:0]       seed,
    input  logic [31:0]       s_tdata,
    input  lebg_pkg::dp_cmd_t cmd,
    output lebg_pkg::dp_sts_t sts,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata
);

    logic [31:0] time_reg;
    logic [31:0] arg_reg, arg_next;
    logic [15:0] div_per_reg, div_per_next;
    logic        fade_reg, fade_next;
    logic [7:0]  br_reg, br_next;
    logic [15:0] per_reg, per_next;
    logic [15:0] rem_reg;
    logic [7:0]  quo_reg;
    logic        full_reg;
    logic [31:0] rand_reg;
    logic [7:0]  candle_level_reg;
    logic [31:0] candle_slot_reg;
    logic [23:0] out_data_reg;
    logic        out_valid_reg;

    logic [32:0] t_inc;
    logic [15:0] half_span;
    logic [15:0] per_blink, per_adv;
    logic [16:0] hold_end;
    logic [31:0] slot;
    logic [31:0] rand_step;
    logic [7:0]  candle_new;
    logic        candle_hit;

    logic [32:0] arg_inc;
    logic [16:0] rem_shift;
    logic [16:0] rem_diff;

    logic [3:0]  idx0, idx1;
    logic [7:0]  y0, y1, dy;
    logic [12:0] prod;
    logic [7:0]  interp_br;

    assign t_inc     = {1'b0, time_reg} + 33'd1;
    assign half_span = {1'b0, cfg.time_span[15:1]};
    assign per_blink = cfg.time_on + cfg.time_off;
    assign per_adv   = cfg.time_span + cfg.time_on + cfg.time_off;
    assign hold_end  = {1'b0, cfg.time_span} + {1'b0, cfg.time_on};
    assign slot      = time_reg >> cfg.flicker_speed;

    assign rand_step  = rand_reg[0] ? (rand_reg >> 1)
                                    : ((rand_reg >> 1) ^ lebg_pkg::RAND_FEEDBACK);
    assign candle_new = (rand_step[7:0] >= cfg.flicker_jitter) ? lebg_pkg::FULL_LEVEL
                      : lebg_pkg::CANDLE_BASE + lebg_pkg::FLICKER_TAB[rand_step[3:0]];
    assign candle_hit = (cfg.mode == lebg_pkg::MODE_CANDLE) && (slot != candle_slot_reg);

    always_comb begin
        arg_next     = time_reg;
        div_per_next = cfg.time_span;
        fade_next    = 1'b0;
        br_next      = 8'd0;
        per_next     = 16'd0;
        case (cfg.mode)
            lebg_pkg::MODE_CONST: begin
                br_next  = cfg.level;
                per_next = 16'd1;
            end
            lebg_pkg::MODE_BLINK: begin
                br_next  = (time_reg < {16'd0, cfg.time_on}) ? lebg_pkg::FULL_LEVEL : 8'd0;
                per_next = per_blink;
            end
            lebg_pkg::MODE_FADEON: begin
                fade_next = 1'b1;
                per_next  = cfg.time_span;
            end
            lebg_pkg::MODE_FADEOFF: begin
                fade_next = 1'b1;
                arg_next  = {16'd0, cfg.time_span} - time_reg;
                per_next  = cfg.time_span;
            end
            lebg_pkg::MODE_BREATHE: begin
                per_next     = cfg.time_span;
                div_per_next = half_span;
                if (t_inc >= {17'd0, cfg.time_span}) begin
                    br_next = 8'd0;
                end else if (time_reg < {16'd0, half_span}) begin
                    fade_next = 1'b1;
                end else begin
                    fade_next = 1'b1;
                    arg_next  = {16'd0, cfg.time_span} - time_reg;
                end
            end
            lebg_pkg::MODE_ADVBR: begin
                per_next = per_adv;
                if (time_reg < {16'd0, cfg.time_span}) begin
                    fade_next = 1'b1;
                end else if (time_reg < {15'd0, hold_end}) begin
                    br_next = lebg_pkg::FULL_LEVEL;
                end else if (time_reg < {16'd0, per_adv}) begin
                    fade_next    = 1'b1;
                    arg_next     = {16'd0, per_adv} - time_reg;
                    div_per_next = cfg.time_off;
                end else begin
                    br_next = 8'd0;
                end
            end
            lebg_pkg::MODE_CANDLE: begin
                per_next = cfg.time_span;
                br_next  = candle_hit ? candle_new : candle_level_reg;
            end
            default: begin
                br_next  = 8'd0;
                per_next = 16'd0;
            end
        endcase
    end

    assign arg_inc   = {1'b0, arg_reg} + 33'd1;
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, div_per_reg};

    assign idx0      = {1'b0, quo_reg[7:5]};
    assign idx1      = idx0 + 4'd1;
    assign y0        = lebg_pkg::CURVE_PTS[idx0];
    assign y1        = lebg_pkg::CURVE_PTS[idx1];
    assign dy        = y1 - y0;
    assign prod      = {8'd0, quo_reg[4:0]} * {5'd0, dy};
    assign interp_br = y0 + prod[12:5];

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            time_reg <= s_tdata;
        end
        if (cmd.select) begin
            arg_reg     <= arg_next;
            div_per_reg <= div_per_next;
            br_reg      <= br_next;
            per_reg     <= per_next;
        end
        if (cmd.load) begin
            full_reg <= (arg_inc >= {17'd0, div_per_reg});
            rem_reg  <= arg_reg[15:0];
            quo_reg  <= '0;
        end
        if (cmd.divide) begin
            if (!rem_diff[16]) begin
                rem_reg <= rem_diff[15:0];
                quo_reg <= {quo_reg[6:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[15:0];
                quo_reg <= {quo_reg[6:0], 1'b0};
            end
        end
        if (cmd.interp) begin
            br_reg <= full_reg ? lebg_pkg::FULL_LEVEL : interp_br;
        end
        if (cmd.out_load) begin
            out_data_reg <= {per_reg, br_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fade_reg         <= 1'b0;
            rand_reg         <= '0;
            candle_level_reg <= lebg_pkg::CANDLE_RESET;
            candle_slot_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.select) begin
                fade_reg <= fade_next;
            end
            if (seed_wr) begin
                rand_reg <= seed;
            end else if (cmd.select && candle_hit) begin
                rand_reg         <= rand_step;
                candle_level_reg <= candle_new;
                candle_slot_reg  <= slot;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.fade_req = fade_reg;
    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;

endmodule

// File: rtl/core/led_effect_brightness_generator_unit.sv
// LED effect brightness generator: each transfer on the s_ side carries a time value in ticks
// and yields one m_ transfer with the brightness and the period of the effect selected by the
// mode register (constant, blink, fade on, fade off, breathe, advanced breathe, candle). Items
// are handled one at a time; for the constant, blink and candle effects and for times outside
// a fade the item passes ST_SELECT, ST_LOAD and ST_DONE before the result is registered; when
// the fade curve is evaluated ST_DIVIDE, where the 8-step bit-serial divider scales time to
// the fade length, and ST_INTERP come between ST_LOAD and ST_DONE. A stalled m_tready keeps
// the next result waiting in ST_DONE until the output register is free. A new item is taken
// while the previous result still waits on m_tready. Registers sit on an APB port at byte
// address 4*i; write them only while no item is in flight. Writing random_seed reloads the
// candle random generator.
module led_effect_brightness_generator_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] time_now
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] brightness, [23:8] effect_period
);

    lebg_pkg::cfg_t    cfg_reg;
    logic [31:0]       seed_reg;
    logic              wr_en;
    logic [2:0]        reg_idx;
    lebg_pkg::dp_cmd_t cmd;
    lebg_pkg::dp_sts_t sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg  <= '0;
            seed_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                lebg_pkg::REG_MODE:   cfg_reg.mode           <= pwdata[2:0];
                lebg_pkg::REG_LEVEL:  cfg_reg.level          <= pwdata[7:0];
                lebg_pkg::REG_SPAN:   cfg_reg.time_span      <= pwdata[15:0];
                lebg_pkg::REG_ON:     cfg_reg.time_on        <= pwdata[15:0];
                lebg_pkg::REG_OFF:    cfg_reg.time_off       <= pwdata[15:0];
                lebg_pkg::REG_SPEED:  cfg_reg.flicker_speed  <= pwdata[4:0];
                lebg_pkg::REG_JITTER: cfg_reg.flicker_jitter <= pwdata[7:0];
                lebg_pkg::REG_SEED:   seed_reg               <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            lebg_pkg::REG_MODE:   prdata = {29'd0, cfg_reg.mode};
            lebg_pkg::REG_LEVEL:  prdata = {24'd0, cfg_reg.level};
            lebg_pkg::REG_SPAN:   prdata = {16'd0, cfg_reg.time_span};
            lebg_pkg::REG_ON:     prdata = {16'd0, cfg_reg.time_on};
            lebg_pkg::REG_OFF:    prdata = {16'd0, cfg_reg.time_off};
            lebg_pkg::REG_SPEED:  prdata = {27'd0, cfg_reg.flicker_speed};
            lebg_pkg::REG_JITTER: prdata = {24'd0, cfg_reg.flicker_jitter};
            lebg_pkg::REG_SEED:   prdata = seed_reg;
            default:              prdata = '0;
        endcase
    end

    lebg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lebg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .seed_wr  (wr_en && (reg_idx == lebg_pkg::REG_SEED)),
        .seed     (pwdata),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: rtl/core/lebg_checker.sv
module lebg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one item at a time
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in flight");

    // a result never appears the cycle after a transfer in
    a_min_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result too early");

    // no result out of reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind led_effect_brightness_generator_unit lebg_checker u_lebg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
